@@ src/hjs_pkg.sv @@
// ----------------------------------------------------------------------------
// hjs_pkg
// Shared widths, register indexes, reset values and types for the
// five-point Jacobi heat stencil sweep.
// ----------------------------------------------------------------------------
package hjs_pkg;

  localparam int VALUE_W    = 32;
  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int SIZE_W     = 11;
  localparam int COEF_W     = 17;
  localparam int COEF_FRAC  = 16;
  localparam int THR_W      = 31;
  localparam int MAG_W      = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // laplacian term, product, sum and difference widths
  localparam int LAP_W  = VALUE_W + 2;
  localparam int PROD_W = LAP_W + COEF_W + 1;
  localparam int SUM_W  = LAP_W + 2;
  localparam int DIFF_W = VALUE_W + 1;

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC);

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONV_THR  = 3'd4;

  localparam logic [SIZE_W-1:0] RST_GRID_ROWS = 11'd82;
  localparam logic [SIZE_W-1:0] RST_GRID_COLS = 11'd82;
  localparam logic [COEF_W-1:0] RST_COEF      = 17'd16384;
  localparam logic [THR_W-1:0]  RST_CONV_THR  = 31'd11;

  typedef struct packed {
    logic [SIZE_W-1:0] grid_rows;
    logic [SIZE_W-1:0] grid_cols;
    logic [COEF_W-1:0] coef_x;
    logic [COEF_W-1:0] coef_y;
    logic [THR_W-1:0]  conv_threshold;
  } cfg_t;

  // raster position of an accepted cell and what it triggers
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             right_ok;
    logic             produce;
    logic             last;
  } pos_t;

  // write into the second line store
  typedef struct packed {
    logic               we;
    logic [COL_W-1:0]   addr;
    logic [VALUE_W-1:0] data;
  } line_wr_t;

endpackage

@@ src/hjs_raster.sv @@
// ----------------------------------------------------------------------------
// hjs_raster
// Raster position counters: clamps the frame size, tags each accepted
// cell with its row, column and interior/last flags.
// ----------------------------------------------------------------------------
module hjs_raster import hjs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [SIZE_W-1:0] grid_rows,
  input  logic [SIZE_W-1:0] grid_cols,
  output pos_t              pos
);

  logic [ROW_W-1:0]  row_count;
  logic [COL_W-1:0]  col_count;
  logic [SIZE_W-1:0] rows;
  logic [SIZE_W-1:0] cols;
  logic [ROW_W-1:0]  r;
  logic [COL_W-1:0]  c;
  logic [SIZE_W-1:0] r1;
  logic [SIZE_W-1:0] c1;
  logic [SIZE_W-1:0] c2;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] res;
    res = v;
    if (v < SIZE_W'(3)) begin
      res = SIZE_W'(3);
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

  always_comb begin
    rows = clamp_size(grid_rows, SIZE_W'(MAX_ROWS));
    cols = clamp_size(grid_cols, SIZE_W'(MAX_COLS));
    r    = (SIZE_W'(row_count) >= rows) ? '0 : row_count;
    c    = (SIZE_W'(col_count) >= cols) ? '0 : col_count;
    r1   = SIZE_W'(r) + SIZE_W'(1);
    c1   = SIZE_W'(c) + SIZE_W'(1);
    c2   = SIZE_W'(c) + SIZE_W'(2);
    pos.row      = r;
    pos.col      = c;
    pos.right_ok = c1 < cols;
    pos.produce  = (r >= ROW_W'(2)) && (c >= COL_W'(1)) && (c1 < cols);
    pos.last     = (r1 == rows) && (c2 == cols);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (fire) begin
      if (c1 >= cols) begin
        col_count <= '0;
        row_count <= (r1 >= rows) ? '0 : r1[ROW_W-1:0];
      end else begin
        col_count <= c1[COL_W-1:0];
        row_count <= r;
      end
    end
  end

endmodule

@@ src/hjs_line_store.sv @@
// ----------------------------------------------------------------------------
// hjs_line_store
// Two line memories (row above, two rows above) with registered reads,
// plus the zeroing pass that runs after reset.
// ----------------------------------------------------------------------------
module hjs_line_store import hjs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      acc,
  input  pos_t                      pos,
  input  logic signed [VALUE_W-1:0] down,
  input  line_wr_t                  two_wr,
  output logic                      busy,
  output logic signed [VALUE_W-1:0] centre,
  output logic signed [VALUE_W-1:0] up,
  output logic signed [VALUE_W-1:0] right
);

  logic signed [VALUE_W-1:0] above_mem [MAX_COLS];
  logic signed [VALUE_W-1:0] two_mem   [MAX_COLS];
  logic                      clearing;
  logic [COL_W-1:0]          clr_addr;
  logic [COL_W-1:0]          right_addr;
  logic signed [VALUE_W-1:0] right_q;
  logic                      right_ok_q;

  assign right_addr = pos.col + COL_W'(1);
  assign busy       = clearing;
  assign right      = right_ok_q ? right_q : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + COL_W'(1);
      if (clr_addr == COL_W'(MAX_COLS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // row above: written with the incoming cell, read at its column and the next
  always_ff @(posedge clk) begin
    if (clearing) begin
      above_mem[clr_addr] <= '0;
    end else if (acc) begin
      above_mem[pos.col] <= down;
    end
    if (acc) begin
      centre     <= above_mem[pos.col];
      right_q    <= above_mem[right_addr];
      right_ok_q <= pos.right_ok;
    end
  end

  // two rows above: written with the old centre one stage later
  always_ff @(posedge clk) begin
    if (clearing) begin
      two_mem[clr_addr] <= '0;
    end else if (two_wr.we) begin
      two_mem[two_wr.addr] <= two_wr.data;
    end
    if (acc) begin
      up <= (two_wr.we && two_wr.addr == pos.col) ? two_wr.data : two_mem[pos.col];
    end
  end

endmodule

@@ src/hjs_update.sv @@
// ----------------------------------------------------------------------------
// hjs_update
// Stencil arithmetic pipeline: scaled laplacian terms, saturated new value,
// change magnitude, running maximum and the result register.
// ----------------------------------------------------------------------------
module hjs_update import hjs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      fire,
  input  pos_t                      pos,
  input  logic signed [VALUE_W-1:0] down,
  input  logic signed [VALUE_W-1:0] centre,
  input  logic signed [VALUE_W-1:0] up,
  input  logic signed [VALUE_W-1:0] right,
  input  cfg_t                      cfg,
  output logic                      s1_free,
  output line_wr_t                  two_wr,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic signed [VALUE_W-1:0] new_value,
  output logic [ROW_W-1:0]          out_row,
  output logic [COL_W-1:0]          out_col,
  output logic                      last_of_sweep,
  output logic [MAG_W-1:0]          max_change,
  output logic                      converged
);

  localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [MAG_W-1:0]          MAG_SAT = '1;

  // stage 1: cell and line store data
  logic                      s1_v;
  pos_t                      s1_pos;
  logic signed [VALUE_W-1:0] s1_down;
  logic signed [VALUE_W-1:0] left;
  // stage 2: scaled terms
  logic                      s2_v;
  pos_t                      s2_pos;
  logic signed [VALUE_W-1:0] s2_centre;
  logic signed [LAP_W-1:0]   s2_dy;
  logic signed [LAP_W-1:0]   s2_dx;
  // stage 3: saturated new value
  logic                      s3_v;
  pos_t                      s3_pos;
  logic signed [VALUE_W-1:0] s3_centre;
  logic signed [VALUE_W-1:0] s3_nv;
  // stage 4: change magnitude
  logic                      s4_v;
  pos_t                      s4_pos;
  logic signed [VALUE_W-1:0] s4_nv;
  logic [MAG_W-1:0]          s4_mag;

  logic [MAG_W-1:0]          running_max;

  logic                      o_free, s4_free, s3_free, s2_free;
  logic                      s4_mv, s3_mv, s2_mv, s1_mv;

  logic signed [LAP_W-1:0]   lap_y, lap_x;
  logic signed [COEF_W:0]    cy_s, cx_s;
  logic signed [PROD_W-1:0]  prod_y, prod_x;
  logic signed [SUM_W-1:0]   sum;
  logic signed [VALUE_W-1:0] nv_sat;
  logic signed [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]         mag_full;
  logic [MAG_W-1:0]          mag;
  logic [MAG_W-1:0]          new_max;

  // bubble-collapsing flow
  always_comb begin
    o_free  = !result_valid || result_ready;
    s4_mv   = s4_v && o_free;
    s4_free = !s4_v || o_free;
    s3_mv   = s3_v && s4_free;
    s3_free = !s3_v || s4_free;
    s2_mv   = s2_v && s3_free;
    s2_free = !s2_v || s3_free;
    s1_mv   = s1_v && s2_free;
    s1_free = !s1_v || s2_free;
  end

  assign two_wr.we   = s1_mv;
  assign two_wr.addr = s1_pos.col;
  assign two_wr.data = centre;

  always_comb begin
    cy_s   = {1'b0, cfg.coef_y};
    cx_s   = {1'b0, cfg.coef_x};
    lap_y  = LAP_W'(up) + LAP_W'(s1_down) - (LAP_W'(centre) <<< 1);
    lap_x  = LAP_W'(left) + LAP_W'(right) - (LAP_W'(centre) <<< 1);
    prod_y = PROD_W'(lap_y) * PROD_W'(cy_s);
    prod_x = PROD_W'(lap_x) * PROD_W'(cx_s);
  end

  always_comb begin
    sum = SUM_W'(s2_centre) + SUM_W'(s2_dy) + SUM_W'(s2_dx);
    if (sum > SUM_W'(VMAX)) begin
      nv_sat = VMAX;
    end else if (sum < SUM_W'(VMIN)) begin
      nv_sat = VMIN;
    end else begin
      nv_sat = sum[VALUE_W-1:0];
    end
  end

  always_comb begin
    diff     = DIFF_W'(s3_nv) - DIFF_W'(s3_centre);
    mag_full = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    mag      = (mag_full > DIFF_W'(MAG_SAT)) ? MAG_SAT : mag_full[MAG_W-1:0];
    new_max  = (s4_mag > running_max) ? s4_mag : running_max;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      s3_v         <= 1'b0;
      s4_v         <= 1'b0;
      result_valid <= 1'b0;
      left         <= '0;
      running_max  <= '0;
    end else begin
      if (s1_free) begin
        s1_v <= fire;
      end
      if (s2_free) begin
        s2_v <= s1_mv && s1_pos.produce;
      end
      if (s3_free) begin
        s3_v <= s2_mv;
      end
      if (s4_free) begin
        s4_v <= s3_mv;
      end
      if (o_free) begin
        result_valid <= s4_mv;
      end
      if (s1_mv) begin
        left <= centre;
      end
      if (s4_mv) begin
        running_max <= s4_pos.last ? '0 : new_max;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_pos  <= pos;
      s1_down <= down;
    end
    if (s2_free && s1_mv) begin
      s2_pos    <= s1_pos;
      s2_centre <= centre;
      s2_dy     <= prod_y[COEF_FRAC+LAP_W-1:COEF_FRAC];
      s2_dx     <= prod_x[COEF_FRAC+LAP_W-1:COEF_FRAC];
    end
    if (s2_mv) begin
      s3_pos    <= s2_pos;
      s3_centre <= s2_centre;
      s3_nv     <= nv_sat;
    end
    if (s3_mv) begin
      s4_pos <= s3_pos;
      s4_nv  <= s3_nv;
      s4_mag <= mag;
    end
    if (s4_mv) begin
      new_value     <= s4_nv;
      out_row       <= s4_pos.row - ROW_W'(1);
      out_col       <= s4_pos.col;
      last_of_sweep <= s4_pos.last;
      max_change    <= new_max;
      converged     <= s4_pos.last && (new_max < cfg.conv_threshold);
    end
  end

endmodule

@@ src/heat_jacobi_stencil_sweep.sv @@
// ----------------------------------------------------------------------------
// heat_jacobi_stencil_sweep
// One Jacobi sweep of the 2D heat equation over a raster-streamed frame.
// ----------------------------------------------------------------------------
// Cells of the frame, halo border included, enter on cell_value with
// cell_valid/cell_ready in raster order. For each interior cell one
// result leaves on result_valid/result_ready once the cell below it has
// been accepted; border cells produce no result.
// One cell is taken per cycle while cell_ready is high. The result of an
// interior cell is shown once the request carrying the cell below it is
// accepted: the accepting edge loads the line store read, then the scaled
// terms, saturated sum, change magnitude and running maximum follow in turn.
// The configuration port writes a register on any cycle with cfg_wr_en;
// write it only while the block is empty.
// After reset the two line stores are zeroed, one column per cycle, over
// all 1024 columns; cell_ready stays low during that pass.
// When the receiver stalls, the stages ahead of the result register
// still fill: up to four more cells are held before cell_ready drops,
// and border cells keep passing while the stage after the input is empty.
// ----------------------------------------------------------------------------
module heat_jacobi_stencil_sweep import hjs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cell_valid,
  output logic                      cell_ready,
  input  logic signed [VALUE_W-1:0] cell_value,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic signed [VALUE_W-1:0] new_value,
  output logic [ROW_W-1:0]          out_row,
  output logic [COL_W-1:0]          out_col,
  output logic                      last_of_sweep,
  output logic [MAG_W-1:0]          max_change,
  output logic                      converged,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  cfg_t                      cfg;
  logic                      fire;
  logic                      busy;
  logic                      s1_free;
  pos_t                      pos;
  line_wr_t                  two_wr;
  logic signed [VALUE_W-1:0] centre;
  logic signed [VALUE_W-1:0] up;
  logic signed [VALUE_W-1:0] right;
  logic [COEF_W-1:0]         coef_in;

  assign cell_ready = !busy && s1_free;
  assign fire       = cell_valid && cell_ready;

  // coefficients above one in the low 17 data bits are stored as one; higher bits are dropped
  assign coef_in = (cfg_data[COEF_FRAC] && (|cfg_data[COEF_FRAC-1:0])) ?
                   COEF_ONE : cfg_data[COEF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_rows      <= RST_GRID_ROWS;
      cfg.grid_cols      <= RST_GRID_COLS;
      cfg.coef_x         <= RST_COEF;
      cfg.coef_y         <= RST_COEF;
      cfg.conv_threshold <= RST_CONV_THR;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_GRID_ROWS: cfg.grid_rows      <= cfg_data[SIZE_W-1:0];
        CFG_GRID_COLS: cfg.grid_cols      <= cfg_data[SIZE_W-1:0];
        CFG_COEF_X:    cfg.coef_x         <= coef_in;
        CFG_COEF_Y:    cfg.coef_y         <= coef_in;
        CFG_CONV_THR:  cfg.conv_threshold <= cfg_data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  hjs_raster u_raster (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .grid_rows (cfg.grid_rows),
    .grid_cols (cfg.grid_cols),
    .pos       (pos)
  );

  hjs_line_store u_line_store (
    .clk    (clk),
    .rst    (rst),
    .acc    (fire),
    .pos    (pos),
    .down   (cell_value),
    .two_wr (two_wr),
    .busy   (busy),
    .centre (centre),
    .up     (up),
    .right  (right)
  );

  hjs_update u_update (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .pos           (pos),
    .down          (cell_value),
    .centre        (centre),
    .up            (up),
    .right         (right),
    .cfg           (cfg),
    .s1_free       (s1_free),
    .two_wr        (two_wr),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .new_value     (new_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .last_of_sweep (last_of_sweep),
    .max_change    (max_change),
    .converged     (converged)
  );

endmodule
